FILE: design/psd_pkg.sv
// shared types and constants of the pointer shake detector
`default_nettype none

package psd_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_IDLECHK,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } psd_state_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_X_SWING  = 2'd0,
    REG_Y_BAND   = 2'd1,
    REG_IDLE     = 2'd2,
    REG_HOLDOFF  = 2'd3
  } psd_reg_e;

  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned THRESH_W = 15;
  localparam int unsigned SEC_W    = 8;
  localparam int unsigned TIME_W   = 32;

  localparam logic [THRESH_W-1:0] X_SWING_RST = 15'd40;
  localparam logic [THRESH_W-1:0] Y_BAND_RST  = 15'd10;
  localparam logic [SEC_W-1:0]    IDLE_RST    = 8'd1;
  localparam logic [SEC_W-1:0]    HOLDOFF_RST = 8'd2;

  localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7fff;

  // running extents of the scanned entries
  typedef struct packed {
    logic signed [DELTA_W-1:0] left;
    logic signed [DELTA_W-1:0] right;
    logic signed [DELTA_W-1:0] top;
    logic signed [DELTA_W-1:0] bottom;
  } psd_ext_t;

endpackage

`default_nettype wire

FILE: design/psd_extent.sv
// min/max and count accumulator fed one ring entry per cycle while en_i is high
`default_nettype none

module psd_extent import psd_pkg::*; #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    clear_i,
  input  wire                                    en_i,
  input  wire  logic signed [DELTA_W-1:0]        x_i,
  input  wire  logic signed [DELTA_W-1:0]        y_i,
  output logic [$clog2(RING_DEPTH+1)-1:0]        count_o,
  output psd_ext_t                               ext_o
);

  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  psd_ext_t        ext_q, ext_d;
  logic            take;

  // an entry counts only when both coordinates are nonzero
  assign take = en_i && (x_i != '0) && (y_i != '0);

  always_comb begin
    count_d = count_q;
    ext_d   = ext_q;
    if (clear_i) begin
      count_d = '0;
    end else if (take) begin
      count_d = count_q + CntW'(1);
      if (count_q == '0) begin
        ext_d.left   = x_i;
        ext_d.right  = x_i;
        ext_d.top    = y_i;
        ext_d.bottom = y_i;
      end else begin
        if (x_i < ext_q.left)   ext_d.left   = x_i;
        if (x_i > ext_q.right)  ext_d.right  = x_i;
        if (y_i < ext_q.top)    ext_d.top    = y_i;
        if (y_i > ext_q.bottom) ext_d.bottom = y_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // extents are only meaningful once count is nonzero
  always_ff @(posedge clk_i) begin
    ext_q <= ext_d;
  end

  assign count_o = count_q;
  assign ext_o   = ext_q;

endmodule

`default_nettype wire

FILE: design/pointer_shake_detector_core.sv
// top level of the pointer shake detector: sequencer, delta ring and apb registers
//
// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  delta_x_i, delta_y_i, now_seconds_i, suppress_i
// out       output     out_valid_o/out_ready_i shake_detected_o
// cfg       apb        psel/penable/pwrite    paddr, pwdata, prdata
//
// a motion report: CHECK, SCAN, DRAIN, DECIDE, DONE; the ring scan reads one entry per cycle
// through the single read port of the ring memory into one shared min/max unit
// reports without motion go CHECK, IDLECHK, DONE; suppressed or held-off ones CHECK, DONE
// one transaction is in work at a time; a new one is taken while the last result waits
// a result still waiting in the output register holds the sequencer in its last state
// reset clears the ring valid bits, registers and counters at once, no clearing pass
`default_nettype none

module pointer_shake_detector_core import psd_pkg::*; #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // report channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  logic signed [DELTA_W-1:0]  delta_x_i,
  input  wire  logic signed [DELTA_W-1:0]  delta_y_i,
  input  wire  logic [TIME_W-1:0]          now_seconds_i,
  input  wire                              suppress_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             shake_detected_o,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  logic [3:0]                 paddr,
  input  wire  logic [31:0]                pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] HALF    = CntW'(RING_DEPTH / 2);

  // configuration registers
  logic [THRESH_W-1:0] x_swing_q, y_band_q;
  logic [SEC_W-1:0]    idle_q, holdoff_len_q;
  logic                cfg_we;
  psd_reg_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = psd_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_swing_q     <= X_SWING_RST;
      y_band_q      <= Y_BAND_RST;
      idle_q        <= IDLE_RST;
      holdoff_len_q <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_X_SWING: x_swing_q     <= pwdata[THRESH_W-1:0];
        REG_Y_BAND:  y_band_q      <= pwdata[THRESH_W-1:0];
        REG_IDLE:    idle_q        <= pwdata[SEC_W-1:0];
        REG_HOLDOFF: holdoff_len_q <= pwdata[SEC_W-1:0];
        default:     ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_X_SWING: prdata = {17'd0, x_swing_q};
      REG_Y_BAND:  prdata = {17'd0, y_band_q};
      REG_IDLE:    prdata = {24'd0, idle_q};
      REG_HOLDOFF: prdata = {24'd0, holdoff_len_q};
      default:     prdata = '0;
    endcase
  end

  // transaction latch
  psd_state_e                 state_q, state_d;
  logic signed [DELTA_W-1:0]  dx_q, dy_q;
  logic [TIME_W-1:0]          now_q;
  logic                       sup_q;
  logic                       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q  <= delta_x_i;
      dy_q  <= delta_y_i;
      now_q <= now_seconds_i;
      sup_q <= suppress_i;
    end
  end

  // detector state
  logic [AW-1:0]       slot_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic [TIME_W-1:0]   last_motion_q, holdoff_until_q, holdoff_end_q;
  logic                holdoff_active_q;
  logic [AW-1:0]       scan_idx_q;
  logic                result_q;
  logic                out_valid_q, shake_q;

  // per-state conditions
  logic                      motion, blocked, idle_expired, shake_hit, out_free;
  logic signed [DELTA_W-1:0] ny;
  logic [TIME_W:0]           idle_limit, holdoff_sum;
  logic [CntW-1:0]           ext_count;
  psd_ext_t                  ext;
  logic signed [DELTA_W:0]   xt, yt;

  assign motion   = (dx_q != '0) || (dy_q != '0);
  assign blocked  = sup_q || (holdoff_active_q && (now_q <= holdoff_until_q));
  assign ny       = (dy_q == DELTA_MIN) ? DELTA_MAX : -dy_q;
  assign idle_limit   = {1'b0, last_motion_q} + {{(TIME_W+1-SEC_W){1'b0}}, idle_q};
  assign idle_expired = {1'b0, now_q} > idle_limit;
  assign holdoff_sum  = {1'b0, now_q} + {{(TIME_W+1-SEC_W){1'b0}}, holdoff_len_q};
  assign xt = {2'b00, x_swing_q};
  assign yt = {2'b00, y_band_q};
  // extents widened by one bit so the most negative value negates cleanly
  assign shake_hit = (ext_count > HALF)
                  && ($signed({ext.right[DELTA_W-1], ext.right}) > xt)
                  && (-$signed({ext.left[DELTA_W-1], ext.left}) > xt)
                  && ($signed({ext.bottom[DELTA_W-1], ext.bottom}) < yt)
                  && (-$signed({ext.top[DELTA_W-1], ext.top}) < yt);
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (accept) state_d = S_CHECK;
      S_CHECK: begin
        if (blocked)     state_d = S_DONE;
        else if (motion) state_d = S_SCAN;
        else             state_d = S_IDLECHK;
      end
      S_IDLECHK: state_d = S_DONE;
      S_SCAN:    if (scan_idx_q == LAST_SLOT) state_d = S_DRAIN;
      S_DRAIN:   state_d = S_DECIDE;
      S_DECIDE:  state_d = S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ring memory, one write and one registered read a cycle
  logic signed [DELTA_W-1:0] ring_x_mem [RING_DEPTH];
  logic signed [DELTA_W-1:0] ring_y_mem [RING_DEPTH];
  logic signed [DELTA_W-1:0] rd_x_q, rd_y_q;
  logic                      rd_ok_q;
  logic                      mem_we;

  assign mem_we = (state_q == S_CHECK) && !blocked && motion;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_x_mem[slot_q] <= dx_q;
      ring_y_mem[slot_q] <= ny;
    end
    rd_x_q <= ring_x_mem[scan_idx_q];
    rd_y_q <= ring_y_mem[scan_idx_q];
  end

  // read qualifier: only written entries reach the extent unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= (state_q == S_SCAN) && valid_q[scan_idx_q];
    end
  end

  psd_extent #(
    .RING_DEPTH(RING_DEPTH)
  ) u_extent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mem_we),
    .en_i    (rd_ok_q),
    .x_i     (rd_x_q),
    .y_i     (rd_y_q),
    .count_o (ext_count),
    .ext_o   (ext)
  );

  // saturated hold-off end, formed while the scan runs
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      holdoff_end_q <= holdoff_sum[TIME_W] ? '1 : holdoff_sum[TIME_W-1:0];
    end
  end

  // detector state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q           <= '0;
      valid_q          <= '0;
      last_motion_q    <= '0;
      holdoff_until_q  <= '0;
      holdoff_active_q <= 1'b0;
      scan_idx_q       <= '0;
      result_q         <= 1'b0;
    end else begin
      unique case (state_q)
        S_CHECK: begin
          result_q   <= 1'b0;
          scan_idx_q <= '0;
          if (!blocked) begin
            holdoff_active_q <= 1'b0;
            if (motion) valid_q[slot_q] <= 1'b1;
          end
        end
        S_IDLECHK: begin
          if (idle_expired) begin
            valid_q       <= '0;
            slot_q        <= '0;
            last_motion_q <= now_q;
          end
        end
        S_SCAN: begin
          if (scan_idx_q != LAST_SLOT) scan_idx_q <= scan_idx_q + AW'(1);
        end
        S_DECIDE: begin
          last_motion_q <= now_q;
          if (shake_hit) begin
            result_q         <= 1'b1;
            holdoff_active_q <= 1'b1;
            holdoff_until_q  <= holdoff_end_q;
            valid_q          <= '0;
            slot_q           <= AW'(1);
          end else begin
            slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      shake_q     <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
      shake_q     <= result_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign shake_detected_o = shake_q;

  // a detection arms the hold-off and empties the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && shake_hit) |=> (holdoff_active_q && valid_q == '0))
    else $error("shake did not arm hold-off or clear ring");

  // no new report is taken while the ring is being scanned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_DRAIN) |-> !in_ready_o)
    else $error("report accepted during scan");

  // extent count never exceeds the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_count <= CntW'(RING_DEPTH))
    else $error("extent count overflow");

  // write slot stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LAST_SLOT)
    else $error("write slot out of range");

endmodule

`default_nettype wire
